FILE: hdl/bvwm_pkg.sv
// ----------------------------------------------------------------------------
// bvwm_pkg
// Shared types and constants for the battery voltage warning monitor:
// field widths, divider sizing, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package bvwm_pkg;

	// ADC full-scale code; valid range 255..65535
	localparam int ADC_FULL_SCALE = 1023;

	localparam int RAW_W = 10;
	localparam int V_W   = 8;
	localparam int CNT_W = 6;

	localparam int CHECK_DELAY    = 10;
	localparam int LOW_PAUSE      = 50;
	localparam int CRITICAL_PAUSE = 5;
	localparam int PAUSE_RANGE    = LOW_PAUSE - CRITICAL_PAUSE;
	localparam int COUNT_MAX      = (1 << CNT_W) - 1;
	localparam int SMOOTH_WEIGHT  = 9;
	localparam int SMOOTH_DIV     = 10;

	localparam logic [V_W-1:0] CAL_RESET  = 8'd255;
	localparam logic [V_W-1:0] LOW_RESET  = 8'd105;
	localparam logic [V_W-1:0] CRIT_RESET = 8'd100;

	// divisor width follows the full-scale constant (at least 8 bits)
	localparam int DVS_W = $clog2(ADC_FULL_SCALE + 1);

	// dividend widths of the three divisions
	localparam int PROD_W = RAW_W + V_W;
	// scaled sample never exceeds the raw code since full scale >= 255
	localparam int SCALED_W = RAW_W;
	localparam int SUM_W = $clog2((1 << RAW_W) + SMOOTH_WEIGHT * 255);
	localparam int LVL_W = $clog2(PAUSE_RANGE * 255 + 1);

	// radix-4: two quotient bits per cycle
	localparam int SCALE_STEPS  = (PROD_W + 1) / 2;
	localparam int SMOOTH_STEPS = (SUM_W + 1) / 2;
	localparam int RANGE_STEPS  = (LVL_W + 1) / 2;
	localparam int DIV_W        = 2 * SCALE_STEPS;
	localparam int STEP_W       = $clog2(SCALE_STEPS + 1);

	typedef enum logic [1:0] {
		REG_CAL  = 2'd0,
		REG_LOW  = 2'd1,
		REG_CRIT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SMOOTH_LD,
		ST_SMOOTH,
		ST_FILT,
		ST_CHECK,
		ST_RANGE,
		ST_RELOAD,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_DEC,
		CNT_CHECK_DELAY,
		CNT_MIN_PAUSE,
		CNT_QUOT
	} cnt_op_t;

	typedef struct packed {
		logic    load_in;
		logic    div_step;
		logic    load_smooth;
		logic    upd_filt;
		logic    load_range;
		cnt_op_t cnt_op;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic cnt_zero;
		logic above_low;
		logic range_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/battery_voltage_warning_monitor_unit.sv
// ----------------------------------------------------------------------------
// battery_voltage_warning_monitor_unit
// Scales and smooths battery ADC samples and paces low-voltage beep requests.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------
// in      | sink      | in_valid / in_ready  | raw_sample[9:0]
// out     | source    | out_valid / out_ready| smoothed_voltage[7:0], buzz_request
// cfg     | sink      | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[7:0]
//
// One sample at a time: a new sample is accepted only after the current one
// has been handed to the output register. The shared radix-4 divider serves
// the full-scale scaling, the /10 filter and the pause division in turn.
// The result sits in an output register, so a sample can be taken while the
// previous beat waits; a stalled output holds the sequencer in its last state.
// Reset is immediate; cfg_ready is always high.
// ----------------------------------------------------------------------------
module battery_voltage_warning_monitor_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bvwm_pkg::RAW_W-1:0]  raw_sample,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bvwm_pkg::V_W-1:0]    smoothed_voltage,
	output logic                        buzz_request,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [bvwm_pkg::V_W-1:0]    cfg_data
);
	import bvwm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bvwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bvwm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.raw_sample       (raw_sample),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.smoothed_voltage (smoothed_voltage),
		.buzz_request     (buzz_request)
	);

	// result only moves into a free output register
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");

	// one sample in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second sample accepted while busy");

	// pause division only when the countdown expired at or below the low threshold with a nonzero range
	a_range_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_range |-> (sts.cnt_zero && !sts.above_low && !sts.range_zero))
		else $error("pause division started without a warning");

	// a finished item reaches the output in the cycle after the load
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

endmodule

FILE: hdl/bvwm_ctrl.sv
// ----------------------------------------------------------------------------
// bvwm_ctrl
// Sequencer: steps one sample through scaling, smoothing, the countdown
// check and the optional pause division, then hands the result off.
// ----------------------------------------------------------------------------
module bvwm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output bvwm_pkg::cmd_t  cmd,
	input  bvwm_pkg::sts_t  sts
);
	import bvwm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.cnt_op = CNT_HOLD;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SMOOTH_LD;
				end
			end
			ST_SMOOTH_LD: begin
				cmd.load_smooth = 1'b1;
				state_d         = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FILT;
				end
			end
			ST_FILT: begin
				cmd.upd_filt = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.cnt_zero) begin
					cmd.cnt_op = CNT_DEC;
					state_d    = ST_FINISH;
				end else if (sts.above_low) begin
					cmd.cnt_op = CNT_CHECK_DELAY;
					state_d    = ST_FINISH;
				end else if (sts.range_zero) begin
					cmd.cnt_op = CNT_MIN_PAUSE;
					state_d    = ST_FINISH;
				end else begin
					cmd.load_range = 1'b1;
					state_d        = ST_RANGE;
				end
			end
			ST_RANGE: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RELOAD;
				end
			end
			ST_RELOAD: begin
				cmd.cnt_op = CNT_QUOT;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/bvwm_dp.sv
// ----------------------------------------------------------------------------
// bvwm_dp
// Datapath: config registers, shared radix-4 restoring divider, filter and
// countdown state, warning flag and the output register.
// ----------------------------------------------------------------------------
module bvwm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bvwm_pkg::RAW_W-1:0]  raw_sample,
	input  logic                        cfg_valid,
	input  logic [1:0]                  cfg_index,
	input  logic [bvwm_pkg::V_W-1:0]    cfg_data,
	input  bvwm_pkg::cmd_t              cmd,
	output bvwm_pkg::sts_t              sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bvwm_pkg::V_W-1:0]    smoothed_voltage,
	output logic                        buzz_request
);
	import bvwm_pkg::*;

	logic [V_W-1:0]    cal_q;
	logic [V_W-1:0]    low_q;
	logic [V_W-1:0]    crit_q;
	logic [V_W-1:0]    filt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              buzz_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] steps_q;
	logic [V_W-1:0]    out_v_q;
	logic              out_buzz_q;

	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	// divider step, two bits
	logic [DVS_W:0]    r1;
	logic [DVS_W:0]    r2;
	logic [DVS_W-1:0]  rem1;
	logic [DVS_W-1:0]  rem2;
	logic              q1;
	logic              q2;

	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;
	logic [V_W-1:0]    level;
	logic [V_W-1:0]    range_v;
	logic [LVL_W-1:0]  lvl_prod;
	logic [V_W-1:0]    filt_sat;
	logic [CNT_W:0]    pause;
	logic [CNT_W-1:0]  reload;

	always_comb begin
		r1   = {rem_q, dvd_q[DIV_W-1]};
		q1   = r1 >= {1'b0, dvs_q};
		rem1 = q1 ? DVS_W'(r1 - {1'b0, dvs_q}) : r1[DVS_W-1:0];
		r2   = {rem1, dvd_q[DIV_W-2]};
		q2   = r2 >= {1'b0, dvs_q};
		rem2 = q2 ? DVS_W'(r2 - {1'b0, dvs_q}) : r2[DVS_W-1:0];
	end

	assign prod     = PROD_W'(raw_sample) * PROD_W'(cal_q);
	assign sum      = SUM_W'(quo_q[SCALED_W-1:0]) + SUM_W'(filt_q) * SUM_W'(SMOOTH_WEIGHT);
	assign range_v  = low_q - crit_q;
	assign level    = (filt_q > crit_q) ? filt_q - crit_q : '0;
	assign lvl_prod = LVL_W'(level) * LVL_W'(PAUSE_RANGE);
	assign filt_sat = (|quo_q[DIV_W-1:V_W]) ? '1 : quo_q[V_W-1:0];
	assign pause    = {1'b0, quo_q[CNT_W-1:0]} + (CNT_W+1)'(CRITICAL_PAUSE);
	assign reload   = ((|quo_q[DIV_W-1:CNT_W]) || pause[CNT_W]) ?
		CNT_W'(COUNT_MAX) : pause[CNT_W-1:0];

	assign sts.div_last   = (steps_q == STEP_W'(1));
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.above_low  = (filt_q > low_q);
	assign sts.range_zero = (range_v == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q       <= CAL_RESET;
			low_q       <= LOW_RESET;
			crit_q      <= CRIT_RESET;
			filt_q      <= LOW_RESET;
			cnt_q       <= CNT_W'(LOW_PAUSE);
			out_valid_q <= 1'b0;
			steps_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CAL:  cal_q  <= cfg_data;
					REG_LOW:  low_q  <= cfg_data;
					REG_CRIT: crit_q <= cfg_data;
					default:  ;
				endcase
			end
			if (cmd.load_in) begin
				steps_q <= STEP_W'(SCALE_STEPS);
			end else if (cmd.load_smooth) begin
				steps_q <= STEP_W'(SMOOTH_STEPS);
			end else if (cmd.load_range) begin
				steps_q <= STEP_W'(RANGE_STEPS);
			end else if (cmd.div_step) begin
				steps_q <= steps_q - STEP_W'(1);
			end
			if (cmd.upd_filt) begin
				filt_q <= filt_sat;
			end
			case (cmd.cnt_op)
				CNT_DEC:         cnt_q <= cnt_q - CNT_W'(1);
				CNT_CHECK_DELAY: cnt_q <= CNT_W'(CHECK_DELAY);
				CNT_MIN_PAUSE:   cnt_q <= CNT_W'(CRITICAL_PAUSE);
				CNT_QUOT:        cnt_q <= reload;
				default:         ;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dvd_q <= DIV_W'(prod) << (DIV_W - 2 * SCALE_STEPS);
			dvs_q <= DVS_W'(ADC_FULL_SCALE);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.load_smooth) begin
			dvd_q <= DIV_W'(sum) << (DIV_W - 2 * SMOOTH_STEPS);
			dvs_q <= DVS_W'(SMOOTH_DIV);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.load_range) begin
			dvd_q <= DIV_W'(lvl_prod) << (DIV_W - 2 * RANGE_STEPS);
			dvs_q <= DVS_W'(range_v);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 2;
			rem_q <= rem2;
			quo_q <= {quo_q[DIV_W-3:0], q1, q2};
		end
		// any countdown action settles this beat's warning flag
		if (cmd.cnt_op != CNT_HOLD) begin
			buzz_q <= (cmd.cnt_op == CNT_MIN_PAUSE) || (cmd.cnt_op == CNT_QUOT);
		end
		if (cmd.out_load) begin
			out_v_q    <= filt_q;
			out_buzz_q <= buzz_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign smoothed_voltage = out_v_q;
	assign buzz_request     = out_buzz_q;

endmodule

FILE: test/bvwm_checker.sv
// ----------------------------------------------------------------------------
// bvwm_checker
// Watches the sample, result and register channels of the battery voltage
// warning monitor. Keeps its own copy of the filter and countdown state,
// predicts each reading on every accepted sample and compares it with the
// result beats in order.
// ----------------------------------------------------------------------------
module bvwm_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [bvwm_pkg::RAW_W-1:0] raw_sample,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [bvwm_pkg::V_W-1:0]   smoothed_voltage,
	input  logic                       buzz_request,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [bvwm_pkg::V_W-1:0]   cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         beeps
);
	timeunit 1ns;
	timeprecision 1ps;

	import bvwm_pkg::*;

	typedef struct packed {
		logic [V_W-1:0] volt;
		logic           buzz;
	} reading_t;

	reading_t expected_readings[$];

	logic [V_W-1:0]   cal_v, low_v, crit_v;
	logic [V_W-1:0]   filt_v;
	logic [CNT_W-1:0] countdown;
	int               err_cnt;
	int               beep_cnt;

	function automatic reading_t advance_monitor(input logic [RAW_W-1:0] raw);
		int unsigned    scaled;
		int unsigned    sum;
		int unsigned    level;
		int unsigned    quot;
		int unsigned    pause;
		logic [V_W-1:0] range;
		reading_t       r;
		scaled = (int'(raw) * int'(cal_v)) / ADC_FULL_SCALE;
		sum = (scaled + SMOOTH_WEIGHT * int'(filt_v)) / SMOOTH_DIV;
		filt_v = (sum > 255) ? 8'd255 : sum[V_W-1:0];
		r.volt = filt_v;
		r.buzz = 1'b0;
		if (countdown != 0) begin
			countdown = countdown - 1'b1;
		end else if (filt_v > low_v) begin
			countdown = CNT_W'(CHECK_DELAY);
		end else begin
			// range wraps when critical sits above low; level is then 0 anyway
			range = low_v - crit_v;
			level = (filt_v > crit_v) ? int'(filt_v - crit_v) : 0;
			quot = (range != 0) ? (PAUSE_RANGE * level) / int'(range) : 0;
			pause = quot + CRITICAL_PAUSE;
			countdown = (pause > COUNT_MAX) ? CNT_W'(COUNT_MAX) : pause[CNT_W-1:0];
			r.buzz = 1'b1;
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t got;
		reading_t want;
		if (!arst_n) begin
			cal_v = CAL_RESET;
			low_v = LOW_RESET;
			crit_v = CRIT_RESET;
			filt_v = LOW_RESET;
			countdown = CNT_W'(LOW_PAUSE);
			err_cnt = 0;
			beep_cnt = 0;
			expected_readings.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CAL:  cal_v = cfg_data;
					REG_LOW:  low_v = cfg_data;
					REG_CRIT: crit_v = cfg_data;
					default: ;
				endcase
			end
			// retire the oldest expectation before queuing this edge's sample
			if (out_valid && out_ready) begin
				got = '{smoothed_voltage, buzz_request};
				if (expected_readings.size() == 0) begin
					note_mismatch("unexpected result beat, voltage", -1, got.volt);
				end else begin
					want = expected_readings.pop_front();
					if (got.volt !== want.volt)
						note_mismatch("smoothed_voltage", want.volt, got.volt);
					if (got.buzz !== want.buzz)
						note_mismatch("buzz_request", want.buzz, got.buzz);
					if (want.buzz)
						beep_cnt++;
				end
			end
			if (in_valid && in_ready)
				expected_readings.push_back(advance_monitor(raw_sample));
		end
		errors <= err_cnt;
		pending <= expected_readings.size();
		beeps <= beep_cnt;
	end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the battery voltage warning monitor. Sends directed and
// random ADC samples through a series of threshold and calibration settings,
// with random idling on both channels and one long output hold-off; the
// checker predicts every reading and beep and reports mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bvwm_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 75;
	localparam int IDLE_PCT     = 27;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 60;
	localparam int LIMIT_CYCLES = 400000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [RAW_W-1:0] raw_sample;
	logic             out_valid;
	logic             out_ready;
	logic [V_W-1:0]   smoothed_voltage;
	logic             buzz_request;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [V_W-1:0]   cfg_data;

	int errors;
	int pending;
	int beeps;
	int samples_sent;
	int reg_writes;
	logic calm;
	logic hold_go;

	int unsigned cal_tab[PHASES]  = '{255, 255, 128, 0, 255, 200, 255, 255, 1, 180, 0, 0};
	int unsigned low_tab[PHASES]  = '{105, 255,  60, 0,  80,  40, 255,   0, 10, 150, 0, 0};
	int unsigned crit_tab[PHASES] = '{100,   0,  20, 0,  79, 200, 255,   0,  5,  30, 0, 0};
	logic [RAW_W-1:0] directed[12] = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512,
		10'd1022, 10'h0FF, 10'h300, 10'd0, 10'd1023, 10'd420};

	battery_voltage_warning_monitor_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_sample       (raw_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.smoothed_voltage (smoothed_voltage),
		.buzz_request     (buzz_request),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	bvwm_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_sample       (raw_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.smoothed_voltage (smoothed_voltage),
		.buzz_request     (buzz_request),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.errors           (errors),
		.pending          (pending),
		.beeps            (beeps)
	);

	// starts low so there is no rising edge at time zero
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// sample near the thresholds most of the time so the warning path is hit
	function automatic logic [RAW_W-1:0] pick_raw(input int unsigned cal, input int lo_t,
			input int hi_t);
		int lo_b;
		int hi_b;
		int tgt;
		int unsigned r;
		lo_b = ((lo_t < hi_t) ? lo_t : hi_t) - 12;
		hi_b = ((lo_t < hi_t) ? hi_t : lo_t) + 12;
		if (lo_b < 0) lo_b = 0;
		if (hi_b > 255) hi_b = 255;
		if ($urandom_range(99) < 30 || cal == 0)
			return RAW_W'($urandom_range(1023));
		if ($urandom_range(99) < 5)
			return $urandom_range(1) ? 10'd1023 : 10'd0;
		tgt = lo_b + $urandom_range(hi_b - lo_b);
		r = (tgt * 1023 + $urandom_range(cal)) / cal;
		return (r > 1023) ? 10'd1023 : r[RAW_W-1:0];
	endfunction

	task automatic send_sample(input logic [RAW_W-1:0] r);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		raw_sample <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
	endtask

	task automatic settle();
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned cal, input int unsigned low,
			input int unsigned crit, input bit poke_unused);
		logic [1:0] idx[4];
		logic [7:0] val[4];
		int n;
		idx = '{REG_CAL, REG_LOW, REG_CRIT, REG_UNUSED};
		val = '{cal[7:0], low[7:0], crit[7:0], 8'($urandom_range(255))};
		n = poke_unused ? 4 : 3;
		in_valid <= 1'b0;
		settle();
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				out_ready <= 1'b0;
				hold_go <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d readings outstanding", LIMIT_CYCLES, pending);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		raw_sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CAL;
		cfg_data <= '0;
		calm <= 1'b0;
		hold_go <= 1'b0;
		samples_sent = 0;
		reg_writes = 0;
		for (int p = PHASES - 2; p < PHASES; p++) begin
			cal_tab[p] = $urandom_range(255);
			low_tab[p] = $urandom_range(255);
			crit_tab[p] = $urandom_range(255);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: countdown still running, filter starts at the low threshold
		foreach (directed[i])
			send_sample(directed[i]);

		for (int p = 0; p < PHASES; p++) begin
			set_config(cal_tab[p], low_tab[p], crit_tab[p], p[0]);
			if (p == 2)
				hold_go <= 1'b1;
			calm <= (p == 4);
			repeat (PHASE_ITEMS)
				send_sample(pick_raw(cal_tab[p], low_tab[p], crit_tab[p]));
		end
		in_valid <= 1'b0;
		settle();

		$display("sent %0d samples across %0d register settings (%0d register writes)",
			samples_sent, PHASES + 1, reg_writes);
		$display("saw %0d warning beeps, including zero-range and inverted thresholds", beeps);
		if (errors == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
hdl/bvwm_pkg.sv
hdl/bvwm_ctrl.sv
hdl/bvwm_dp.sv
hdl/battery_voltage_warning_monitor_unit.sv
test/bvwm_checker.sv
test/tb_top.sv
